>>> hdl/beep_cue_pulse_generator_assert.svh
// Assertion macros for the beeper pulse train RTL.
// No dependencies; included by beep_cue_pulse_generator.
`ifndef BEEP_CUE_PULSE_GENERATOR_ASSERT_SVH
`define BEEP_CUE_PULSE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge, switched off while reset is asserted.
`define BCPG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define BCPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCPG_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCPG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hdl/bcpg_pkg.sv
// Types, codes and the cue table of the beeper pulse train generator.
// No dependencies; imported by beep_cue_pulse_generator and its testbench.
package bcpg_pkg;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_PLAY   = 2'd1,
		OP_STOP   = 2'd2
	} opcode_t;

	localparam logic [2:0] CUE_NONE       = 3'd0;
	localparam logic [2:0] CUE_START      = 3'd1;
	localparam logic [2:0] CUE_CHECKPOINT = 3'd2;
	localparam logic [2:0] CUE_FINISH     = 3'd3;
	localparam logic [2:0] CUE_FAULT      = 3'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  cue;
		logic [31:0] now_ms;
	} cmd_t;

	typedef struct packed {
		logic beeper_level;
		logic level_written;
		logic busy_res;
	} res_t;

	typedef struct packed {
		logic [2:0] pulses;
		logic [7:0] on_ms;
		logic [7:0] off_ms;
	} cue_entry_t;

	// A cue with zero pulses leaves the generator untouched.
	function automatic cue_entry_t cue_lookup(input logic [2:0] cue);
		cue_entry_t e;
		case (cue)
			CUE_START:      e = '{pulses: 3'd1, on_ms: 8'd120, off_ms: 8'd80};
			CUE_CHECKPOINT: e = '{pulses: 3'd1, on_ms: 8'd80,  off_ms: 8'd60};
			CUE_FINISH:     e = '{pulses: 3'd2, on_ms: 8'd150, off_ms: 8'd100};
			CUE_FAULT:      e = '{pulses: 3'd4, on_ms: 8'd80,  off_ms: 8'd80};
			CUE_NONE:       e = '{pulses: 3'd0, on_ms: 8'd0,   off_ms: 8'd0};
			default:        e = '{pulses: 3'd0, on_ms: 8'd0,   off_ms: 8'd0};
		endcase
		return e;
	endfunction

endpackage

>>> hdl/beep_cue_pulse_generator.sv
// The result of a command transaction passes from the input register into the result
// register once the command is accepted, and from there it appears on res.
// Throughput: one transaction per cycle, set by the single state update between the input
// and result registers; a result left waiting stalls the input stage.
// Reset (arst_n low, asynchronous): beeper off, idle, pulse count, durations and
// deadline zero, both pipeline stages empty.
`include "beep_cue_pulse_generator_assert.svh"

module beep_cue_pulse_generator
	import bcpg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	cmd_t        cmd_s1;
	logic        valid_s1;
	res_t        res_q;
	logic        res_valid_q;

	logic [2:0]  pulses_q;
	logic [7:0]  on_dur_q;
	logic [7:0]  off_dur_q;
	logic        level_q;
	logic        running_q;
	logic [31:0] deadline_q;

	logic [2:0]  pulses_d;
	logic [7:0]  on_dur_d;
	logic [7:0]  off_dur_d;
	logic        level_d;
	logic        running_d;
	logic [31:0] deadline_d;
	logic        written;

	logic        advance;
	cue_entry_t  entry;
	logic [7:0]  add_ms;
	logic [31:0] sched;
	logic [31:0] diff;
	logic [2:0]  pulses_dec;

	// The stage moves forward when the result register is empty or being drained.
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign entry      = cue_lookup(cmd_s1.cue);
	assign diff       = cmd_s1.now_ms - deadline_q;
	assign pulses_dec = pulses_q - 3'd1;
	// A play schedules the end of the first on phase; an update the end of the next phase.
	assign add_ms     = (cmd_s1.opcode == OP_PLAY) ? entry.on_ms :
		(level_q ? off_dur_q : on_dur_q);
	assign sched      = cmd_s1.now_ms + {24'd0, add_ms};

	always_comb begin
		pulses_d   = pulses_q;
		on_dur_d   = on_dur_q;
		off_dur_d  = off_dur_q;
		level_d    = level_q;
		running_d  = running_q;
		deadline_d = deadline_q;
		written    = 1'b0;
		case (cmd_s1.opcode)
			OP_PLAY: begin
				if (entry.pulses != 3'd0) begin
					pulses_d   = entry.pulses;
					on_dur_d   = entry.on_ms;
					off_dur_d  = entry.off_ms;
					level_d    = 1'b1;
					running_d  = 1'b1;
					deadline_d = sched;
					written    = 1'b1;
				end
			end
			OP_STOP: begin
				running_d = 1'b0;
				level_d   = 1'b0;
				written   = 1'b1;
			end
			OP_UPDATE: begin
				// The deadline has passed when the wrapped difference is not negative.
				if (running_q && !diff[31]) begin
					written = 1'b1;
					if (level_q) begin
						level_d  = 1'b0;
						pulses_d = pulses_dec;
						if (pulses_dec == 3'd0) begin
							running_d = 1'b0;
						end else begin
							deadline_d = sched;
						end
					end else begin
						level_d    = 1'b1;
						deadline_d = sched;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pulses_q    <= 3'd0;
			on_dur_q    <= 8'd0;
			off_dur_q   <= 8'd0;
			level_q     <= 1'b0;
			running_q   <= 1'b0;
			deadline_q  <= 32'd0;
		end else begin
			if (advance) begin
				res_valid_q <= 1'b1;
				pulses_q    <= pulses_d;
				on_dur_q    <= on_dur_d;
				off_dur_q   <= off_dur_d;
				level_q     <= level_d;
				running_q   <= running_d;
				deadline_q  <= deadline_d;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= '{beeper_level: level_d, level_written: written, busy_res: running_d};
		end
	end

	`BCPG_ASSERT(a_level_needs_run, clk, arst_n, level_q |-> running_q, "beeper on while idle")
	`BCPG_ASSERT(a_run_has_pulses, clk, arst_n, running_q |-> (pulses_q != 3'd0), "running with no pulses left")
	`BCPG_ASSERT(a_res_tracks_state, clk, arst_n, res_valid_q |-> (res_q.beeper_level == level_q && res_q.busy_res == running_q), "result disagrees with state")
	`BCPG_ASSERT(a_stage_holds, clk, arst_n, (valid_s1 && !advance) |=> (valid_s1 && $stable(cmd_s1)), "stalled input stage changed")

endmodule

>>> verif/beep_cue_pulse_generator_tb.sv
// Self-checking testbench for the beeper pulse train generator: directed cases, random cue
// trains under sender and receiver idling, and a long receiver hold-off.
// Depends on bcpg_pkg and the beep_cue_pulse_generator RTL.
`timescale 1ns / 1ps

module beep_cue_pulse_generator_tb;
	import bcpg_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam logic [2:0] CUE_BAD_LO  = 3'd5;
	localparam logic [2:0] CUE_BAD_HI  = 3'd7;
	localparam int         MAX_SHOWN   = 10;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	res_t res;

	// Predicted generator state.
	logic [2:0]  pulse_cnt;
	logic [7:0]  on_ms_cur;
	logic [7:0]  off_ms_cur;
	logic        beep_on;
	logic        train_active;
	logic [31:0] due_ms;

	res_t pending_beeper_q[$];
	int   mismatch_count;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   stall_request;
	int   stall_left;
	logic [31:0] clock_ms;

	beep_cue_pulse_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #4 clk = ~clk;

	// Advances the predicted state by one command and returns the expected result.
	function automatic res_t beeper_next(input cmd_t c);
		res_t        r;
		logic        wrote;
		logic [31:0] gap;
		logic [2:0]  n;
		logic [7:0]  on_len;
		logic [7:0]  off_len;
		wrote = 1'b0;
		gap = c.now_ms - due_ms;
		n = 3'd0;
		on_len = 8'd0;
		off_len = 8'd0;
		case (c.opcode)
			OP_PLAY: begin
				case (c.cue)
					CUE_START: begin
						n = 3'd1; on_len = 8'd120; off_len = 8'd80;
					end
					CUE_CHECKPOINT: begin
						n = 3'd1; on_len = 8'd80; off_len = 8'd60;
					end
					CUE_FINISH: begin
						n = 3'd2; on_len = 8'd150; off_len = 8'd100;
					end
					CUE_FAULT: begin
						n = 3'd4; on_len = 8'd80; off_len = 8'd80;
					end
					default: begin
						n = 3'd0;
					end
				endcase
				if (n != 3'd0) begin
					pulse_cnt = n;
					on_ms_cur = on_len;
					off_ms_cur = off_len;
					beep_on = 1'b1;
					train_active = 1'b1;
					due_ms = c.now_ms + {24'd0, on_len};
					wrote = 1'b1;
				end
			end
			OP_STOP: begin
				train_active = 1'b0;
				beep_on = 1'b0;
				wrote = 1'b1;
			end
			OP_UPDATE: begin
				// The deadline has passed when the wrapped difference is not negative.
				if (train_active && !gap[31]) begin
					wrote = 1'b1;
					if (beep_on) begin
						beep_on = 1'b0;
						pulse_cnt = pulse_cnt - 3'd1;
						if (pulse_cnt == 3'd0)
							train_active = 1'b0;
						else
							due_ms = c.now_ms + {24'd0, off_ms_cur};
					end else begin
						beep_on = 1'b1;
						due_ms = c.now_ms + {24'd0, on_ms_cur};
					end
				end
			end
			default: begin
			end
		endcase
		r.beeper_level = beep_on;
		r.level_written = wrote;
		r.busy_res = train_active;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is accepted.
	task automatic offer_cmd(input logic [1:0] op, input logic [2:0] cue, input logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{opcode: op, cue: cue, now_ms: t};
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	// Predict on input acceptance, then check the result side.
	always @(posedge clk) begin
		if (arst_n && cmd_valid && cmd_ready)
			pending_beeper_q.push_back(beeper_next(cmd));
		if (arst_n && res_valid && res_ready) begin
			if (pending_beeper_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_SHOWN)
					$display("%0t: unexpected result level=%b written=%b busy=%b", $realtime,
						res.beeper_level, res.level_written, res.busy_res);
			end else begin
				res_t want;
				want = pending_beeper_q.pop_front();
				if (res.beeper_level !== want.beeper_level ||
						res.level_written !== want.level_written ||
						res.busy_res !== want.busy_res) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN)
						$display("%0t: mismatch expected level=%b written=%b busy=%b, got %b %b %b",
							$realtime, want.beeper_level, want.level_written, want.busy_res,
							res.beeper_level, res.level_written, res.busy_res);
				end
			end
		end
	end

	// Receiver: random idling, or a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic test_directed();
		offer_cmd(OP_UPDATE, CUE_NONE, 32'd0);
		offer_cmd(OP_STOP, CUE_NONE, 32'd0);
		offer_cmd(OP_PLAY, CUE_NONE, 32'd5);
		offer_cmd(OP_PLAY, CUE_BAD_LO, 32'd5);
		offer_cmd(OP_PLAY, CUE_BAD_HI, 32'd5);
		offer_cmd(OP_RESERVED, CUE_START, 32'd5);
		// The start deadline wraps past zero.
		offer_cmd(OP_PLAY, CUE_START, 32'hFFFF_FFC0);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'h0000_0037);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'h0000_0038);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'h0000_0200);
		// A difference of exactly half the range counts as early; one less fires.
		offer_cmd(OP_PLAY, CUE_FINISH, 32'd1000);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'd1150 + 32'h8000_0000);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'd1150 + 32'h7FFF_FFFF);
		offer_cmd(OP_PLAY, CUE_FAULT, 32'd2000);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'd2080);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'd2160);
		offer_cmd(OP_STOP, CUE_NONE, 32'd2170);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'd3000);
		offer_cmd(OP_PLAY, CUE_CHECKPOINT, 32'hFFFF_FFFF);
		offer_cmd(OP_UPDATE, CUE_NONE, 32'd79);
		offer_cmd(OP_PLAY, CUE_FINISH, 32'd0);
		offer_cmd(OP_RESERVED, CUE_BAD_HI, 32'hFFFF_FFFF);
		offer_cmd(OP_STOP, CUE_BAD_HI, 32'hFFFF_FFFF);
	endtask

	// Mostly complete cue trains with advancing time, the rest random noise.
	task automatic test_random_trains(input int count);
		int         sent;
		int         steps;
		int         pick;
		logic [2:0] cue;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 2)
				clock_ms = $urandom;
			if ($urandom_range(99) < 78) begin
				cue = 3'($urandom_range(CUE_START, CUE_FAULT));
				offer_cmd(OP_PLAY, cue, clock_ms);
				sent++;
				steps = $urandom_range(3, 16);
				for (int i = 0; i < steps && sent < count; i++) begin
					pick = $urandom_range(99);
					if (pick < 70)
						clock_ms += $urandom_range(0, 60);
					else if (pick < 90)
						clock_ms += $urandom_range(61, 160);
					pick = $urandom_range(99);
					cue = 3'($urandom_range(0, 7));
					if (pick < 90)
						offer_cmd(OP_UPDATE, cue, clock_ms);
					else if (pick < 94)
						offer_cmd(OP_STOP, cue, clock_ms);
					else if (pick < 97)
						offer_cmd(OP_PLAY, cue, clock_ms);
					else
						offer_cmd(OP_RESERVED, cue, clock_ms);
					sent++;
				end
			end else begin
				if ($urandom_range(1) == 0)
					offer_cmd(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom);
				else
					offer_cmd(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
						clock_ms + $urandom_range(0, 300));
				sent++;
			end
		end
	endtask

	// The receiver stops for a long stretch while commands keep coming.
	task automatic test_result_holdoff();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 300;
		test_random_trains(80);
	endtask

	initial begin
		int drain_cycles;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_ready = 1'b0;
		mismatch_count = 0;
		stall_request = 0;
		stall_left = 0;
		send_idle_pct = 21;
		recv_idle_pct = 64;
		clock_ms = $urandom;
		pulse_cnt = 3'd0;
		on_ms_cur = 8'd0;
		off_ms_cur = 8'd0;
		beep_on = 1'b0;
		train_active = 1'b0;
		due_ms = 32'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_trains(400);
		send_idle_pct = 64;
		recv_idle_pct = 21;
		test_random_trains(400);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_trains(400);
		test_result_holdoff();
		cmd_valid <= 1'b0;

		drain_cycles = 0;
		while (pending_beeper_q.size() != 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (8) @(posedge clk);
		if (pending_beeper_q.size() != 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_SHOWN)
				$display("%0d expected results never arrived", pending_beeper_q.size());
		end
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> beep_cue_pulse_generator.f
+incdir+hdl
hdl/bcpg_pkg.sv
hdl/beep_cue_pulse_generator.sv
verif/beep_cue_pulse_generator_tb.sv
